>>> sv/sfir_pkg.sv
// Shared constants, types and control structs of the symmetric FIR filter.
`timescale 1ns / 1ps

package sfir_pkg;

    // Filter geometry.
    localparam int TAPS       = 15;
    localparam int NPAIR      = (TAPS + 1) / 2;
    localparam int NB         = TAPS / 2;
    localparam bit HAS_CENTER = (TAPS % 2) != 0;
    localparam int NCOEF      = 8;

    // Data widths.
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int OUT_W      = 16;
    localparam int FRAC       = 15;
    localparam int PRE_W      = SAMPLE_W + 1;
    localparam int DIG_W      = 4;
    localparam int NDIG       = COEF_W / DIG_W;
    localparam int PP_W       = PRE_W + DIG_W + 1;
    localparam int PROD_W     = PRE_W + COEF_W;
    localparam int ACC_W      = PROD_W + $clog2(NPAIR);

    // Counter and index widths.
    localparam int PAIR_W     = (NPAIR > 1) ? $clog2(NPAIR) : 1;
    localparam int DIG_CNT_W  = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int COEF_IDX_W = $clog2(NCOEF);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [PRE_W-1:0]    pre_t;
    typedef logic [NCOEF-1:0][COEF_W-1:0] coef_bank_t;

    // Sequencer commands to the delay line.
    typedef struct packed {
        logic rotate_a;
        logic rotate_b;
        logic center;
    } step_t;

    // Status of the multiply-accumulate unit.
    typedef struct packed {
        logic             idle;
        logic             done;
        logic [OUT_W-1:0] data;
    } mac_status_t;

endpackage

>>> sv/sfir_delay.sv
// Folded delay line: two rings of samples that present one tap pair at a time.
`timescale 1ns / 1ps

module sfir_delay (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  sfir_pkg::sample_t sample_i,
    input  sfir_pkg::step_t   step_i,
    output sfir_pkg::pre_t    pre_o
);
    import sfir_pkg::*;

    // Front half holds ages 0 .. NPAIR-1, back half holds ages TAPS-1 down to NPAIR.
    sample_t a_reg  [NPAIR];
    sample_t a_next [NPAIR];
    sample_t b_reg  [NB];
    sample_t b_next [NB];

    // A new sample shifts both halves; each pair of a run rotates both by one, the back half not at the center.
    always_comb begin
        a_next = a_reg;
        b_next = b_reg;
        priority if (load) begin
            a_next[0] = sample_i;
            for (int i = 1; i < NPAIR; i++) begin
                a_next[i] = a_reg[i-1];
            end
            for (int j = 0; j < NB - 1; j++) begin
                b_next[j] = b_reg[j+1];
            end
            b_next[NB-1] = a_reg[NPAIR-1];
        end else if (step_i.rotate_a) begin
            for (int i = 0; i < NPAIR; i++) begin
                a_next[i] = a_reg[(i + 1) % NPAIR];
            end
            if (step_i.rotate_b) begin
                for (int j = 0; j < NB; j++) begin
                    b_next[j] = b_reg[(j + 1) % NB];
                end
            end
        end else begin
            // Both halves hold between steps.
            a_next = a_reg;
            b_next = b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NPAIR; i++) begin
                a_reg[i] <= '0;
            end
            for (int j = 0; j < NB; j++) begin
                b_reg[j] <= '0;
            end
        end else begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    // Pre-add of the current pair; the center tap stands alone.
    assign pre_o = step_i.center ? PRE_W'(a_reg[0])
                                 : PRE_W'(a_reg[0]) + PRE_W'(b_reg[0]);

endmodule

>>> sv/sfir_mac.sv
// Digit-serial multiply-accumulate unit with its sequencer and output saturation.
`timescale 1ns / 1ps

module sfir_mac (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic                  ack,
    input  sfir_pkg::pre_t        pre_i,
    input  sfir_pkg::coef_bank_t  coef_i,
    output sfir_pkg::step_t       step_o,
    output sfir_pkg::mac_status_t status_o
);
    import sfir_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FLUSH, ST_DONE} state_t;

    state_t                    state_reg,   state_next;
    logic [PAIR_W-1:0]         pair_reg,    pair_next;
    logic [DIG_CNT_W-1:0]      digit_reg,   digit_next;
    logic [COEF_W-1:0]         coef_sh_reg, coef_sh_next;
    logic signed [PROD_W-1:0]  prod_reg,    prod_next;
    logic signed [ACC_W-1:0]   acc_reg,     acc_next;

    logic                      first_digit;
    logic                      last_digit;
    logic                      last_pair;
    logic [COEF_W-1:0]         coef_sel;
    logic [DIG_W-1:0]          digit;
    logic signed [PP_W-2:0]    pp_top;
    logic signed [PP_W-1:0]    pp_low;
    logic signed [PP_W-1:0]    pp;
    logic signed [PROD_W-1:0]  prod_base;
    logic signed [PROD_W-1:0]  prod_sum;
    logic signed [ACC_W-1:0]   acc_sum;
    logic [ACC_W-FRAC-OUT_W:0] acc_hi;
    logic [OUT_W-1:0]          sat_data;

    assign first_digit = (digit_reg == '0);
    assign last_digit  = (digit_reg == DIG_CNT_W'(NDIG - 1));
    assign last_pair   = (pair_reg == PAIR_W'(NPAIR - 1));

    // The coefficient is consumed most significant digit first; the top digit is signed.
    assign coef_sel = coef_i[COEF_IDX_W'(pair_reg)];
    assign digit    = first_digit ? coef_sel[COEF_W-1 -: DIG_W]
                                  : coef_sh_reg[COEF_W-1 -: DIG_W];

    // One narrow partial product per cycle, folded in Horner style.
    always_comb begin
        pp_top    = (PP_W-1)'(pre_i) * (PP_W-1)'($signed(digit));
        pp_low    = PP_W'(pre_i) * PP_W'($signed({1'b0, digit}));
        pp        = first_digit ? {pp_top[PP_W-2], pp_top} : pp_low;
        prod_base = first_digit ? '0 : {prod_reg[PROD_W-DIG_W-1:0], {DIG_W{1'b0}}};
        prod_sum  = prod_base + {{(PROD_W-PP_W){pp[PP_W-1]}}, pp};
        acc_sum   = acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    end

    // Arithmetic shift right by the fraction width, then clamp to the output range.
    always_comb begin
        acc_hi = acc_reg[ACC_W-1:FRAC+OUT_W-1];
        if ((&acc_hi) || !(|acc_hi)) begin
            sat_data = acc_reg[FRAC+OUT_W-1:FRAC];
        end else if (acc_reg[ACC_W-1]) begin
            sat_data = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            sat_data = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    // Sequencer: steps through the digits of each pair in turn, then a flush of the last product.
    always_comb begin
        state_next   = state_reg;
        pair_next    = pair_reg;
        digit_next   = digit_reg;
        coef_sh_next = coef_sh_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_RUN;
                    pair_next  = '0;
                    digit_next = '0;
                    prod_next  = '0;
                    acc_next   = '0;
                end
            end
            ST_RUN: begin
                prod_next    = prod_sum;
                coef_sh_next = first_digit
                             ? {coef_sel[COEF_W-DIG_W-1:0], {DIG_W{1'b0}}}
                             : {coef_sh_reg[COEF_W-DIG_W-1:0], {DIG_W{1'b0}}};
                if (first_digit) begin
                    acc_next = acc_sum;
                end
                if (last_digit) begin
                    digit_next = '0;
                    if (last_pair) begin
                        state_next = ST_FLUSH;
                    end else begin
                        pair_next = pair_reg + PAIR_W'(1);
                    end
                end else begin
                    digit_next = digit_reg + DIG_CNT_W'(1);
                end
            end
            ST_FLUSH: begin
                acc_next   = acc_sum;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (ack) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pair_reg  <= '0;
            digit_reg <= '0;
        end else begin
            state_reg <= state_next;
            pair_reg  <= pair_next;
            digit_reg <= digit_next;
        end
        coef_sh_reg <= coef_sh_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
    end

    // Delay line steps after the last digit of each pair.
    always_comb begin
        step_o.rotate_a = (state_reg == ST_RUN) && last_digit;
        step_o.center   = HAS_CENTER && last_pair;
        step_o.rotate_b = step_o.rotate_a && !step_o.center;
    end

    assign status_o.idle = (state_reg == ST_IDLE);
    assign status_o.done = (state_reg == ST_DONE);
    assign status_o.data = sat_data;

endmodule

>>> sv/symmetric_fir_filter.sv
// Symmetric (linear-phase) FIR filter, top level with stream and register ports.
//
// Input stream s_*: one signed 16-bit sample per transfer in s_tdata.
// Output stream m_*: one signed 16-bit filtered sample per input, in order.
// Register port cfg_*: cfg_index 0..7 selects coef_0..coef_7 (signed Q1.15),
// cfg_ready is always high; write registers only while no sample is in flight.
// Each coefficient weights a pair of taps, the last one the center tap when
// the tap count is odd; the sum is shifted right by 15 and saturated.
// Timing: the multiplier takes the coefficient 4 bits per cycle, and the tap
// pairs of a sample pass one after another through the shared pre-add/multiply
// unit, followed by a flush of the last product. m_tvalid rises once the result
// moves into a free output register, and s_tready rises in the same cycle: the
// unit takes no new sample until the result of the last one has left it.
// A finished result waits in the output register; if m_tready stays low, a
// second result waits inside the unit and s_tready stays low until it moves.
// Reset (aresetn low at a clock edge) clears the delay line and coefficients
// to zero and empties the output register.
`timescale 1ns / 1ps

module symmetric_fir_filter (
    input  logic        aclk,
    input  logic        aresetn,
    // Input samples.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] audio_in
    // Filtered samples.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] audio_out
    // Coefficient writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import sfir_pkg::*;

    coef_bank_t       coef_reg;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg;
    logic             s_accept;
    logic             out_load;
    pre_t             pre;
    step_t            step;
    mac_status_t      status;

    assign s_tready  = status.idle;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Coefficient registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    sfir_delay u_delay (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (s_accept),
        .sample_i (s_tdata),
        .step_i   (step),
        .pre_o    (pre)
    );

    sfir_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_accept),
        .ack      (out_load),
        .pre_i    (pre),
        .coef_i   (coef_reg),
        .step_o   (step),
        .status_o (status)
    );

    // Output register: takes a result whenever it is empty or being drained.
    assign out_load = status.done && (!m_tvalid_reg || m_tready);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        priority if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        if (out_load) begin
            m_tdata_reg <= status.data;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    // A sample in flight blocks the next input transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("input accepted while a sample is in flight");

    // No result can be finished right after a new sample starts.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !status.done)
        else $error("result ready too early after input transfer");

    // A pending result keeps the input closed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.done |-> !s_tready)
        else $error("input open while a result is pending");

    // A handed-over result appears on the output in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid && (m_tdata == $past(status.data)))
        else $error("output register did not take the result");
`endif

endmodule

>>> bench/symmetric_fir_filter_test.sv
// Self-checking testbench for the symmetric FIR filter: directed table, then random phases.
`timescale 1ns / 1ps

module symmetric_fir_filter_test;

    import sfir_pkg::*;

    // Coefficient register indexes on the configuration port.
    typedef enum logic [COEF_IDX_W-1:0] {
        COEF_0, COEF_1, COEF_2, COEF_3, COEF_4, COEF_5, COEF_6, COEF_7
    } coef_sel_t;

    // A directed row either sends one sample or writes one coefficient.
    typedef enum bit {ROW_SAMPLE, ROW_COEF} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        coef_sel_t   sel;
        logic [15:0] value;
        bit          typed;
        logic [15:0] typed_out;
    } stim_row_t;

    localparam int DIR_ROWS       = 38;
    localparam int RAND_PHASES    = 6;
    localparam int PHASE_SAMPLES  = 108;
    localparam int IDLE_LIMIT     = 4000;
    localparam int DRAIN_CYCLES   = 60;

    // Directed stimulus. Only outputs that are obvious are typed in: zero
    // coefficients after reset give zero, and with coef_0 alone at -1.0 the
    // newest sample is simply negated, clipping for -32768.
    stim_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_SAMPLE, COEF_0, 16'h7FFF, 1'b1, 16'h0000},
        '{ROW_SAMPLE, COEF_0, 16'h8000, 1'b1, 16'h0000},
        '{ROW_SAMPLE, COEF_0, 16'h0000, 1'b1, 16'h0000},
        '{ROW_COEF,   COEF_0, 16'h8000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, COEF_0, 16'h7FFF, 1'b1, 16'h8001},
        '{ROW_SAMPLE, COEF_0, 16'h8000, 1'b1, 16'h7FFF},
        '{ROW_COEF,   COEF_0, 16'h7FFF, 1'b0, 16'h0000},
        '{ROW_COEF,   COEF_1, 16'h8000, 1'b0, 16'h0000},
        '{ROW_COEF,   COEF_2, 16'h7FFF, 1'b0, 16'h0000},
        '{ROW_COEF,   COEF_3, 16'h8000, 1'b0, 16'h0000},
        '{ROW_COEF,   COEF_4, 16'h7FFF, 1'b0, 16'h0000},
        '{ROW_COEF,   COEF_5, 16'h8000, 1'b0, 16'h0000},
        '{ROW_COEF,   COEF_6, 16'h7FFF, 1'b0, 16'h0000},
        '{ROW_COEF,   COEF_7, 16'h8000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, COEF_0, 16'h0001, 1'b0, 16'h0000},
        '{ROW_SAMPLE, COEF_0, 16'hFFFF, 1'b0, 16'h0000},
        '{ROW_SAMPLE, COEF_0, 16'h5555, 1'b0, 16'h0000},
        '{ROW_SAMPLE, COEF_0, 16'hAAAA, 1'b0, 16'h0000},
        '{ROW_SAMPLE, COEF_0, 16'h7FFF, 1'b0, 16'h0000},
        '{ROW_SAMPLE, COEF_0, 16'h8000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, COEF_0, 16'h0000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, COEF_0, 16'h7FFF, 1'b0, 16'h0000},
        '{ROW_COEF,   COEF_0, 16'h7FFF, 1'b0, 16'h0000},
        '{ROW_COEF,   COEF_1, 16'h7FFF, 1'b0, 16'h0000},
        '{ROW_COEF,   COEF_2, 16'h7FFF, 1'b0, 16'h0000},
        '{ROW_COEF,   COEF_3, 16'h7FFF, 1'b0, 16'h0000},
        '{ROW_COEF,   COEF_4, 16'h7FFF, 1'b0, 16'h0000},
        '{ROW_COEF,   COEF_5, 16'h7FFF, 1'b0, 16'h0000},
        '{ROW_COEF,   COEF_6, 16'h7FFF, 1'b0, 16'h0000},
        '{ROW_COEF,   COEF_7, 16'h7FFF, 1'b0, 16'h0000},
        '{ROW_SAMPLE, COEF_0, 16'h8000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, COEF_0, 16'h8000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, COEF_0, 16'h8000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, COEF_0, 16'h8000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, COEF_0, 16'h8000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, COEF_0, 16'h8000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, COEF_0, 16'h8000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, COEF_0, 16'h8000, 1'b0, 16'h0000}
    };

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;    // [15:0] audio_in
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;           // [15:0] audio_out
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    // Filter state as the bench sees it: taps by age, newest first.
    sample_t                   tap_hist [TAPS];
    logic signed [COEF_W-1:0]  coef_reg [NCOEF];
    sample_t                   audio_expect [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int errors         = 0;
    int n_samples      = 0;
    int n_results      = 0;
    int n_coef_writes  = 0;
    int n_clip_hi      = 0;
    int n_clip_lo      = 0;
    int stall_cycles   = 0;

    symmetric_fir_filter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 50 MHz clock.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Shift a new sample into the taps and return the filtered output.
    function automatic sample_t filter_sample(input sample_t smp);
        longint acc;
        longint quo;
        int     k;
        for (k = TAPS - 1; k > 0; k--) begin
            tap_hist[k] = tap_hist[k-1];
        end
        tap_hist[0] = smp;
        acc = 0;
        // Symmetric pairs share one coefficient after the pre-add.
        for (k = 0; k < NB && k < NCOEF; k++) begin
            acc += (longint'(tap_hist[k]) + longint'(tap_hist[TAPS-1-k]))
                   * longint'(coef_reg[k]);
        end
        if (HAS_CENTER && NB < NCOEF) begin
            acc += longint'(tap_hist[NB]) * longint'(coef_reg[NB]);
        end
        // Arithmetic shift floors; then clip to 16 bits.
        quo = acc >>> FRAC;
        if (quo > 32767) begin
            n_clip_hi++;
            quo = 32767;
        end else if (quo < -32768) begin
            n_clip_lo++;
            quo = -32768;
        end
        return sample_t'(quo[15:0]);
    endfunction

    // Random sample: mostly full range, some small, some at the rails.
    function automatic logic [15:0] pick_sample();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            case ($urandom_range(0, 2))
                0:       v = 32767;
                1:       v = -32768;
                default: v = 0;
            endcase
        end else if (r < 40) begin
            v = int'($urandom_range(0, 4095)) - 2048;
        end else begin
            v = int'($urandom_range(0, 65535));
        end
        return v[15:0];
    endfunction

    // Random coefficient: small weights keep many outputs out of clipping.
    function automatic logic [15:0] pick_coef();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            v = int'($urandom_range(0, 8191)) - 4096;
        end else if (r < 80) begin
            v = int'($urandom_range(0, 65535));
        end else if (r < 90) begin
            v = 0;
        end else begin
            v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
        end
        return v[15:0];
    endfunction

    // Send one sample; the expectation is recorded at the transfer.
    task automatic send_sample(input logic [15:0] smp, input bit typed,
                               input logic [15:0] typed_out);
        sample_t predicted;
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = smp;
        do @(posedge aclk); while (!s_tready);
        predicted = filter_sample(sample_t'(smp));
        audio_expect.push_back(typed ? sample_t'(typed_out) : predicted);
        n_samples++;
    endtask

    // Coefficient write, only once every pending output has come back.
    task automatic write_coef(input coef_sel_t sel, input logic [15:0] val);
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (audio_expect.size() != 0) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = sel;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        coef_reg[sel] = val;
        n_coef_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Output backpressure.
    always @(negedge aclk) begin
        m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Compare each output transfer with the oldest expectation.
    always @(posedge aclk) begin : check_output
        sample_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (audio_expect.size() == 0) begin
                $error("audio_out: no output expected, actual %0d",
                       $signed(m_tdata));
                errors++;
            end else begin
                want = audio_expect.pop_front();
                if (m_tdata !== want) begin
                    $error("audio_out mismatch: expected %0d, actual %0d",
                           want, $signed(m_tdata));
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= IDLE_LIMIT) begin
            $display("Timed out with %0d outputs outstanding.", audio_expect.size());
            $display("symmetric_fir_filter regression: fail");
            $finish;
        end
    end

    initial begin : main
        int ph;
        int k;
        int n;
        for (k = 0; k < TAPS; k++) begin
            tap_hist[k] = '0;
        end
        for (k = 0; k < NCOEF; k++) begin
            coef_reg[k] = '0;
        end

        // Reset once, released on a falling edge.
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        // Directed table.
        send_idle_pct  = 12;
        recv_stall_pct = 64;
        for (k = 0; k < DIR_ROWS; k++) begin
            if (dir_rows[k].kind == ROW_COEF) begin
                write_coef(dir_rows[k].sel, dir_rows[k].value);
            end else begin
                send_sample(dir_rows[k].value, dir_rows[k].typed, dir_rows[k].typed_out);
            end
        end

        // Random phases: rail coefficient sets first, then random sets,
        // with the stall pattern changing every two phases.
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph / 2)
                0: begin
                    send_idle_pct  = 12;
                    recv_stall_pct = 64;
                end
                1: begin
                    send_idle_pct  = 64;
                    recv_stall_pct = 12;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (k = 0; k < NCOEF; k++) begin
                write_coef(coef_sel_t'(k),
                           (ph == 0) ? 16'h8000 : (ph == 1) ? 16'h7FFF : pick_coef());
            end
            for (n = 0; n < PHASE_SAMPLES; n++) begin
                send_sample(pick_sample(), 1'b0, 16'h0000);
            end
        end

        // Drain the outputs, then allow a little longer for strays.
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (audio_expect.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d samples and checked %0d outputs across %0d coefficient writes.",
                 n_samples, n_results, n_coef_writes);
        $display("Predicted outputs clipped high %0d times and low %0d times.",
                 n_clip_hi, n_clip_lo);
        if (errors == 0) begin
            $display("symmetric_fir_filter regression: pass");
        end else begin
            $display("symmetric_fir_filter regression: fail");
        end
        $finish;
    end

endmodule
